FILE: hw/rtl/gnmc_pkg.sv
// Shared types and constants for the grid neighbor mine counter.
package gnmc_pkg;

  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_LW    = $clog2(OQ_DEPTH + 1);

  localparam int unsigned ROW_W   = 10;
  localparam int unsigned COL_W   = 5;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned ROWS_W  = 11;
  localparam int unsigned COLS_W  = 6;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             marked;
    logic [CNT_W-1:0] count;
    logic             last;
    logic             endg;
  } gnmc_result_t;

  typedef struct packed {
    logic [OQ_LW-1:0] level;
    logic             valid;
  } gnmc_q_stat_t;

endpackage

FILE: hw/rtl/gnmc_out_fifo.sv
// Result queue taking up to two transactions per cycle and draining one.
module gnmc_out_fifo import gnmc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   push_cnt_i,
  input  gnmc_result_t push0_i,
  input  gnmc_result_t push1_i,
  input  logic         pop_i,
  output gnmc_result_t data_o,
  output gnmc_q_stat_t stat_o
);

  gnmc_result_t     mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] wp_q, wp_d;
  logic [OQ_AW-1:0] rp_q, rp_d;
  logic [OQ_LW-1:0] level_q, level_d;
  logic [OQ_AW-1:0] wp_next;

  assign wp_next = wp_q + OQ_AW'(1);
  assign wp_d    = wp_q + OQ_AW'(push_cnt_i);
  assign rp_d    = rp_q + OQ_AW'(pop_i);
  assign level_d = level_q + OQ_LW'(push_cnt_i) - OQ_LW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wp_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wp_next] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      level_q <= level_d;
    end
  end

  assign data_o       = mem_q[rp_q];
  assign stat_o.level = level_q;
  assign stat_o.valid = (level_q != '0);

endmodule

FILE: hw/rtl/grid_neighbor_mine_count.sv
// Grid neighbor mine counter: streams a binary grid and reports 3x3 neighbor counts.
//
// Cells enter in row-major order; grid_rows and grid_cols are set over the APB port,
// and a write restarts the grid. A column-indexed line memory holds the two rows
// above the current one and is read, updated and written back per cell, so a cell is
// taken every cycle unless input is stalled. A result for cell (r-1,c-1) is formed
// in the column stage after cell (r,c) is taken and then written to the result queue;
// the last column of a row adds one more result. After the final cell of a grid
// the block reads the last row back from the line memory, one column per cycle
// while the queue has room, so input stalls while that row is reported. Results
// drain through a four-entry queue; output stall backs up into input stall.
module grid_neighbor_mine_count import gnmc_pkg::*; #(
  parameter int unsigned MAX_COLS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              cell_is_mine_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ROW_W-1:0]  out_row_o,
  output logic [COL_W-1:0]  out_col_o,
  output logic              cell_marked_o,
  output logic [CNT_W-1:0]  neighbor_count_o,
  output logic              last_of_run_o,
  output logic              end_of_grid_o
);

  localparam int unsigned CW = $clog2(MAX_COLS);

  typedef struct packed {
    logic up;
    logic mid;
    logic down;
  } col_bits_t;

  function automatic logic [CNT_W-1:0] count3x3(col_bits_t l, col_bits_t c, col_bits_t r);
    logic [CNT_W-1:0] s;
    s = CNT_W'(l.up) + CNT_W'(l.mid) + CNT_W'(l.down) + CNT_W'(c.up) + CNT_W'(c.down)
      + CNT_W'(r.up) + CNT_W'(r.mid) + CNT_W'(r.down);
    return c.mid ? '0 : s;
  endfunction

  // configuration
  logic [ROWS_W-1:0] rows_q;
  logic [COLS_W-1:0] cols_q;
  logic              cfg_wr;
  logic [ROW_W-1:0]  rows_last;
  logic [COLS_W-1:0] cols_last;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_W'(1);
      cols_q <= COLS_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROWS: rows_q <= pwdata[ROWS_W-1:0];
        REG_COLS: cols_q <= pwdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS: prdata = DATA_W'(rows_q);
      REG_COLS: prdata = DATA_W'(cols_q);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    if (rows_q == '0) begin
      rows_last = '0;
    end else if (rows_q > ROWS_W'(1024)) begin
      rows_last = ROW_W'(1023);
    end else begin
      rows_last = ROW_W'(rows_q - ROWS_W'(1));
    end
    if (cols_q == '0) begin
      cols_last = '0;
    end else if (cols_q > COLS_W'(MAX_COLS)) begin
      cols_last = COLS_W'(MAX_COLS - 1);
    end else begin
      cols_last = cols_q - COLS_W'(1);
    end
  end

  // input positions and flush sequencing
  logic [ROW_W-1:0] row_q, row_d;
  logic [CW-1:0]    col_q, col_d;
  logic             flushing_q, flushing_d;
  logic [CW-1:0]    fc_q, fc_d;
  logic [ROW_W-1:0] flush_row_q, flush_row_d;
  logic             room;
  logic             in_acc;
  logic             flush_iss;
  logic             issue;
  logic             a_last_col;
  logic             a_last;
  logic             fc_last;
  logic [CW-1:0]    rd_addr;

  assign in_stall_o = flushing_q || !room;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign flush_iss  = flushing_q && room;
  assign issue      = in_acc || flush_iss;
  assign a_last_col = (COLS_W'(col_q) == cols_last);
  assign a_last     = a_last_col && (row_q == rows_last);
  assign fc_last    = (COLS_W'(fc_q) == cols_last);
  assign rd_addr    = flushing_q ? fc_q : col_q;

  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    flushing_d  = flushing_q;
    fc_d        = fc_q;
    flush_row_d = flush_row_q;
    if (cfg_wr) begin
      row_d      = '0;
      col_d      = '0;
      flushing_d = 1'b0;
    end else if (in_acc) begin
      if (a_last) begin
        row_d       = '0;
        col_d       = '0;
        flushing_d  = 1'b1;
        fc_d        = '0;
        flush_row_d = row_q;
      end else if (a_last_col) begin
        row_d = row_q + ROW_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + CW'(1);
      end
    end else if (flush_iss) begin
      fc_d = fc_q + CW'(1);
      if (fc_last) begin
        flushing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      flushing_q <= 1'b0;
      fc_q       <= '0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      flushing_q <= flushing_d;
      fc_q       <= fc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flush_row_q <= flush_row_d;
  end

  // column stage: line memory read lands here
  logic             b_vld_q;
  logic             b_flush_q;
  logic             b_bit_q;
  logic [ROW_W-1:0] b_row_q;
  logic [CW-1:0]    b_col_q;
  logic             b_lastcol_q;
  logic             b_last_q;
  logic [1:0]       line_mem [MAX_COLS];
  logic [1:0]       rd_q;
  logic             fwd_q;
  logic [1:0]       fwd_data_q;
  logic [1:0]       rd_eff;
  logic [1:0]       wr_data;
  logic             wr_en;
  logic             fwd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      b_vld_q <= issue;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_flush_q   <= flushing_q;
      b_bit_q     <= cell_is_mine_i;
      b_row_q     <= flushing_q ? flush_row_q : row_q;
      b_col_q     <= rd_addr;
      b_lastcol_q <= flushing_q ? fc_last : a_last_col;
      b_last_q    <= !flushing_q && a_last;
    end
    fwd_data_q <= wr_data;
  end

  assign rd_eff  = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {rd_eff[0], b_bit_q};
  assign wr_en   = b_vld_q && !b_flush_q;
  assign fwd_d   = issue && wr_en && (rd_addr == b_col_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[b_col_q] <= wr_data;
    end
    rd_q <= line_mem[rd_addr];
  end

  // 3x3 window and result formation
  col_bits_t    win_l_q, win_c_q;
  col_bits_t    t_col;
  col_bits_t    left1, left2;
  logic         row_ge1, row_ge2;
  logic         e1, e2;
  gnmc_result_t r1, r2;
  logic [31:0]  col_ext1, col_ext2;

  assign row_ge1 = (b_row_q != '0);
  assign row_ge2 = (b_row_q > ROW_W'(1));

  always_comb begin
    if (b_flush_q) begin
      t_col.up   = rd_eff[1] && row_ge1;
      t_col.mid  = rd_eff[0];
      t_col.down = 1'b0;
    end else begin
      t_col.up   = rd_eff[1] && row_ge2;
      t_col.mid  = rd_eff[0] && row_ge1;
      t_col.down = b_bit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      win_l_q <= win_c_q;
      win_c_q <= t_col;
    end
  end

  assign e1    = b_vld_q && (b_col_q != '0) && (b_flush_q || row_ge1);
  assign e2    = b_vld_q && b_lastcol_q && (b_flush_q || row_ge1);
  assign left1 = (b_col_q > CW'(1)) ? win_l_q : '0;
  assign left2 = (b_col_q != '0) ? win_c_q : '0;

  assign col_ext1 = 32'(b_col_q - CW'(1));
  assign col_ext2 = 32'(b_col_q);

  always_comb begin
    r1.row    = b_flush_q ? b_row_q : b_row_q - ROW_W'(1);
    r1.col    = col_ext1[COL_W-1:0];
    r1.marked = win_c_q.mid;
    r1.count  = count3x3(left1, win_c_q, t_col);
    r1.last   = !b_flush_q && !b_last_q && !e2;
    r1.endg   = 1'b0;
    r2.row    = r1.row;
    r2.col    = col_ext2[COL_W-1:0];
    r2.marked = t_col.mid;
    r2.count  = count3x3(left2, t_col, '0);
    r2.last   = b_flush_q || !b_last_q;
    r2.endg   = b_flush_q;
  end

  // result queue
  logic [1:0]   push_cnt;
  gnmc_result_t push0;
  gnmc_result_t q_data;
  gnmc_q_stat_t q_stat;
  logic         pop;
  logic [3:0]   level_next;

  assign push_cnt   = 2'(e1) + 2'(e2);
  assign push0      = e1 ? r1 : r2;
  assign pop        = out_valid_o && !out_stall_i;
  assign level_next = 4'(q_stat.level) + 4'(push_cnt) - 4'(pop);
  assign room       = (level_next <= 4'(OQ_DEPTH - 2));

  gnmc_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (push0),
    .push1_i    (r2),
    .pop_i      (pop),
    .data_o     (q_data),
    .stat_o     (q_stat)
  );

  assign out_valid_o      = q_stat.valid;
  assign out_row_o        = q_data.row;
  assign out_col_o        = q_data.col;
  assign cell_marked_o    = q_data.marked;
  assign neighbor_count_o = q_data.count;
  assign last_of_run_o    = q_data.last;
  assign end_of_grid_o    = q_data.endg;

`ifndef SYNTH
  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> in_stall_o)
    else $error("input taken during final row readout");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.level <= OQ_LW'(OQ_DEPTH))
    else $error("result queue overflow");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_grid_o |-> last_of_run_o)
    else $error("end of grid without last of run");

  a_marked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_marked_o |-> neighbor_count_o == '0)
    else $error("marked cell with nonzero count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> neighbor_count_o <= CNT_W'(8))
    else $error("neighbor count above eight");
`endif

endmodule
